@@ rtl/core/tanv_pkg.sv @@
// Shared constants, types and state codes of the three-axis noise variance block.
`default_nettype none
package tanv_pkg;

   localparam int MAX_SAMPLES = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS = 8;
   localparam int AXES = 3;

   localparam int COUNT_BITS = 13;
   localparam int SUM_BITS = 29;
   localparam int SQ_BITS = 45;
   localparam int SQR_BITS = 2 * SAMPLE_BITS;
   localparam int MAG_BITS = SUM_BITS - 1;
   localparam int P1_BITS = COUNT_BITS + SQ_BITS;
   localparam int P2_BITS = 2 * MAG_BITS;
   localparam int NUM_BITS = 56;
   localparam int DVD_BITS = NUM_BITS + FRAC_BITS;
   localparam int STEP_BITS = $clog2(DVD_BITS);
   localparam int NN_BITS = 2 * COUNT_BITS;
   localparam int DIV_BITS = 26;
   localparam int VAR_BITS = 38;
   localparam int STATUS_BITS = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [VAR_BITS-1:0] VAR_MAX = '1;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FEW      = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      BACK_ACC,
      BACK_MUL,
      BACK_ADD,
      BACK_DIV,
      BACK_DONE
   } back_state_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x;
      logic signed [SAMPLE_BITS-1:0] y;
      logic signed [SAMPLE_BITS-1:0] z;
      logic                          drop;
      logic                          last;
   } word_type;

   typedef struct packed {
      logic     valid;
      word_type word;
   } push_type;

endpackage
`default_nettype wire

@@ rtl/core/three_axis_noise_variance.sv @@
// Top level of the three-axis noise variance block: front end, word queue and back end.
`default_nettype none
// Takes one signed three-axis sample word per cycle while a set is being accumulated and,
// on the word marked last, returns the axis-averaged sample variance (divisor N-1) as
// unsigned fixed point with FRAC_BITS fraction bits, truncated and saturated to 38 bits,
// with a status (ok, fewer than two samples, more than MAX_SAMPLES samples) and the count
// used. Samples beyond MAX_SAMPLES in a set are dropped. After the last word the back end
// forms the result in a product step and an add step per axis, the one-bit-per-cycle
// restoring divider and a step that loads the result register, or in the first product
// step and the load when the set holds fewer than two samples; meanwhile the front end
// keeps taking up to four words into the queue. A result waiting in its register stalls
// the back end only at the end of the next set.
module three_axis_noise_variance (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [tanv_pkg::SAMPLE_BITS-1:0] req_sample_x,
   input  wire  [tanv_pkg::SAMPLE_BITS-1:0] req_sample_y,
   input  wire  [tanv_pkg::SAMPLE_BITS-1:0] req_sample_z,
   input  wire                              req_last_sample,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [tanv_pkg::VAR_BITS-1:0]    rsp_mean_variance,
   output logic [tanv_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [tanv_pkg::COUNT_BITS-1:0]  rsp_samples_used
);
   import tanv_pkg::*;

   push_type push;
   logic     push_ready;
   logic     pop_valid;
   word_type pop_word;
   logic     pop_ready;

   tanv_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_x    (req_sample_x),
      .req_sample_y    (req_sample_y),
      .req_sample_z    (req_sample_z),
      .req_last_sample (req_last_sample),
      .push            (push),
      .push_ready      (push_ready)
   );

   tanv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_word   (pop_word),
      .pop_ready  (pop_ready)
   );

   tanv_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_word          (pop_word),
      .pop_ready         (pop_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mean_variance (rsp_mean_variance),
      .rsp_status        (rsp_status),
      .rsp_samples_used  (rsp_samples_used)
   );

endmodule
`default_nettype wire

@@ rtl/core/tanv_front.sv @@
// Front end: takes sample words and marks those beyond the set limit for dropping.
`default_nettype none
module tanv_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [tanv_pkg::SAMPLE_BITS-1:0] req_sample_x,
   input  wire  [tanv_pkg::SAMPLE_BITS-1:0] req_sample_y,
   input  wire  [tanv_pkg::SAMPLE_BITS-1:0] req_sample_z,
   input  wire                              req_last_sample,
   output tanv_pkg::push_type               push,
   input  wire                              push_ready
);
   import tanv_pkg::*;

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  full;
   logic                  take;

   assign full = (count_ff == COUNT_BITS'(MAX_SAMPLES));
   assign take = req_valid & push_ready;
   assign req_ready = push_ready;

   always_comb begin
      push.valid = req_valid;
      push.word.x = signed'(req_sample_x);
      push.word.y = signed'(req_sample_y);
      push.word.z = signed'(req_sample_z);
      push.word.drop = full;
      push.word.last = req_last_sample;
   end

   always_comb begin
      count_in = count_ff;
      if (take) begin
         if (req_last_sample) begin
            count_in = '0;
         end else if (!full) begin
            count_in = count_ff + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/tanv_queue.sv @@
// Short word queue between the front end and the back end.
`default_nettype none
module tanv_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  tanv_pkg::push_type  push,
   output logic                push_ready,
   output logic                pop_valid,
   output tanv_pkg::word_type  pop_word,
   input  wire                 pop_ready
);
   import tanv_pkg::*;

   word_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS:0]   fill_ff;
   logic [QPTR_BITS:0]   fill_in;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = (fill_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_word = slot_ff[rd_ptr_ff];
   assign do_push = push.valid & push_ready;
   assign do_pop = pop_valid & pop_ready;

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (QPTR_BITS+1)'(1);
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - (QPTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.word;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/tanv_back.sv @@
// Back end: accumulates sample words, forms the variance and drives the result register.
`default_nettype none
module tanv_back (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              pop_valid,
   input  tanv_pkg::word_type               pop_word,
   output logic                             pop_ready,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [tanv_pkg::VAR_BITS-1:0]    rsp_mean_variance,
   output logic [tanv_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [tanv_pkg::COUNT_BITS-1:0]  rsp_samples_used
);
   import tanv_pkg::*;

   back_state_type               state_ff, state_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic signed [SUM_BITS-1:0]   sum_ff [AXES];
   logic signed [SUM_BITS-1:0]   sum_in [AXES];
   logic [SQ_BITS-1:0]           sq_ff [AXES];
   logic [SQ_BITS-1:0]           sq_in [AXES];
   logic                         ovf_ff, ovf_in;
   logic [1:0]                   axis_ff, axis_in;
   logic [P1_BITS-1:0]           p1_ff, p1_in;
   logic [P2_BITS-1:0]           p2_ff, p2_in;
   logic [NUM_BITS-1:0]          num_ff, num_in;
   logic [NN_BITS-1:0]           nn_ff, nn_in;
   logic [DIV_BITS-1:0]          d_ff, d_in;
   logic [DIV_BITS-1:0]          rem_ff, rem_in;
   logic [DVD_BITS-1:0]          dvd_ff, dvd_in;
   logic [DVD_BITS-1:0]          quo_ff, quo_in;
   logic [STEP_BITS-1:0]         step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [VAR_BITS-1:0]          rsp_var_ff, rsp_var_in;
   status_type                   rsp_status_ff, rsp_status_in;
   logic [COUNT_BITS-1:0]        rsp_used_ff, rsp_used_in;

   logic signed [SAMPLE_BITS-1:0] smp [AXES];
   logic signed [SQR_BITS-1:0]    smp_sq [AXES];
   logic signed [SUM_BITS-1:0]    sel_sum;
   logic [SUM_BITS-1:0]           sel_abs;
   logic [MAG_BITS-1:0]           sel_mag;
   logic [P1_BITS-1:0]            term;
   logic [DIV_BITS:0]             trial;
   logic                          fits;
   logic                          few;
   logic                          load;

   assign smp[0] = pop_word.x;
   assign smp[1] = pop_word.y;
   assign smp[2] = pop_word.z;

   assign pop_ready = (state_ff == BACK_ACC);
   assign few = (count_ff < COUNT_BITS'(2));
   assign load = (state_ff == BACK_DONE) && (!rsp_valid_ff || rsp_ready);

   assign sel_sum = sum_ff[axis_ff];
   assign sel_abs = sel_sum[SUM_BITS-1] ? SUM_BITS'(-sel_sum) : SUM_BITS'(sel_sum);
   assign sel_mag = sel_abs[MAG_BITS-1:0];
   assign term = p1_ff - P1_BITS'(p2_ff);
   assign trial = {rem_ff, dvd_ff[DVD_BITS-1]};
   assign fits = (trial >= {1'b0, d_ff});

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         smp_sq[a] = smp[a] * smp[a];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_ACC: begin
            if (pop_valid && pop_word.last) begin
               state_in = BACK_MUL;
            end
         end
         BACK_MUL: begin
            state_in = few ? BACK_DONE : BACK_ADD;
         end
         BACK_ADD: begin
            state_in = (axis_ff == 2'(AXES - 1)) ? BACK_DIV : BACK_MUL;
         end
         BACK_DIV: begin
            if (step_ff == STEP_BITS'(DVD_BITS - 1)) begin
               state_in = BACK_DONE;
            end
         end
         BACK_DONE: begin
            if (load) begin
               state_in = BACK_ACC;
            end
         end
         default: begin
            state_in = BACK_ACC;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      sum_in = sum_ff;
      sq_in = sq_ff;
      ovf_in = ovf_ff;
      axis_in = axis_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      num_in = num_ff;
      nn_in = nn_ff;
      d_in = d_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_var_in = rsp_var_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in = rsp_used_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         BACK_ACC: begin
            axis_in = '0;
            if (pop_valid) begin
               if (pop_word.drop) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + COUNT_BITS'(1);
                  for (int a = 0; a < AXES; a++) begin
                     sum_in[a] = sum_ff[a]
                        + {{(SUM_BITS-SAMPLE_BITS){smp[a][SAMPLE_BITS-1]}}, smp[a]};
                     sq_in[a] = sq_ff[a]
                        + {{(SQ_BITS-SQR_BITS){1'b0}}, unsigned'(smp_sq[a])};
                  end
               end
            end
         end
         BACK_MUL: begin
            quo_in = '0;
            p1_in = count_ff * sq_ff[axis_ff];
            p2_in = sel_mag * sel_mag;
            nn_in = count_ff * (count_ff - COUNT_BITS'(1));
         end
         BACK_ADD: begin
            num_in = num_ff + term[NUM_BITS-1:0];
            d_in = DIV_BITS'(nn_ff) + DIV_BITS'({nn_ff, 1'b0});
            axis_in = axis_ff + 2'(1);
            rem_in = '0;
            step_in = '0;
            dvd_in = {num_in, {FRAC_BITS{1'b0}}};
         end
         BACK_DIV: begin
            rem_in = fits ? DIV_BITS'(trial - {1'b0, d_ff}) : trial[DIV_BITS-1:0];
            quo_in = {quo_ff[DVD_BITS-2:0], fits};
            dvd_in = {dvd_ff[DVD_BITS-2:0], 1'b0};
            step_in = step_ff + STEP_BITS'(1);
         end
         BACK_DONE: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_var_in = (|quo_ff[DVD_BITS-1:VAR_BITS]) ? VAR_MAX : quo_ff[VAR_BITS-1:0];
               rsp_used_in = count_ff;
               if (few) begin
                  rsp_status_in = STATUS_FEW;
               end else if (ovf_ff) begin
                  rsp_status_in = STATUS_OVERFLOW;
               end else begin
                  rsp_status_in = STATUS_OK;
               end
               count_in = '0;
               ovf_in = 1'b0;
               num_in = '0;
               for (int a = 0; a < AXES; a++) begin
                  sum_in[a] = '0;
                  sq_in[a] = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_ACC;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         num_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < AXES; a++) begin
            sum_ff[a] <= '0;
            sq_ff[a] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         num_ff <= num_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff <= sum_in;
         sq_ff <= sq_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff <= axis_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      nn_ff <= nn_in;
      d_ff <= d_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      step_ff <= step_in;
      rsp_var_ff <= rsp_var_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff <= rsp_used_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mean_variance = rsp_var_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_samples_used = rsp_used_ff;

endmodule
`default_nettype wire

@@ test/three_axis_noise_variance_tb.sv @@
// Testbench for three_axis_noise_variance: sample sets driven against a running variance predictor.
`default_nettype none
module three_axis_noise_variance_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tanv_pkg::*;

   typedef struct {
      logic [VAR_BITS-1:0]   variance;
      status_type            status;
      logic [COUNT_BITS-1:0] used;
   } variance_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [SAMPLE_BITS-1:0] req_sample_x;
   logic [SAMPLE_BITS-1:0] req_sample_y;
   logic [SAMPLE_BITS-1:0] req_sample_z;
   logic                   req_last_sample;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [VAR_BITS-1:0]    rsp_mean_variance;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [COUNT_BITS-1:0]  rsp_samples_used;

   variance_result_type expected_variances[$];
   int                  mismatch_count;
   int                  words_sent;
   int                  rsp_hold;
   bit                  no_idle;

   int unsigned set_count;
   longint      axis_total[AXES];
   longint      axis_square_total[AXES];
   bit          set_overflowed;

   three_axis_noise_variance DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_x      (req_sample_x),
      .req_sample_y      (req_sample_y),
      .req_sample_z      (req_sample_z),
      .req_last_sample   (req_last_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mean_variance (rsp_mean_variance),
      .rsp_status        (rsp_status),
      .rsp_samples_used  (rsp_samples_used)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("FAIL");
      $finish;
   end

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (no_idle || pick < 55) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(1, 3);
      end else if (pick < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(11, 24);
   endfunction

   function automatic void clear_set();
      set_count = 0;
      set_overflowed = 1'b0;
      for (int a = 0; a < AXES; a++) begin
         axis_total[a] = 0;
         axis_square_total[a] = 0;
      end
   endfunction

   function automatic void absorb_sample(logic [SAMPLE_BITS-1:0] sx, logic [SAMPLE_BITS-1:0] sy,
                                         logic [SAMPLE_BITS-1:0] sz, logic last);
      logic [SAMPLE_BITS-1:0] raw[AXES];
      longint                 v;
      logic [127:0]           numerator;
      logic [127:0]           wide_n;
      logic [127:0]           wide_sq;
      logic [127:0]           wide_mag;
      logic [127:0]           divisor;
      logic [127:0]           quotient;
      variance_result_type    result;
      raw[0] = sx;
      raw[1] = sy;
      raw[2] = sz;
      if (set_count < MAX_SAMPLES) begin
         for (int a = 0; a < AXES; a++) begin
            v = longint'($signed(raw[a]));
            axis_total[a] += v;
            axis_square_total[a] += v * v;
         end
         set_count++;
      end else begin
         set_overflowed = 1'b1;
      end
      if (!last) begin
         return;
      end
      result.variance = '0;
      result.used = set_count[COUNT_BITS-1:0];
      if (set_count < 2) begin
         result.status = STATUS_FEW;
      end else begin
         numerator = '0;
         wide_n = 128'(set_count);
         for (int a = 0; a < AXES; a++) begin
            wide_sq = 128'(axis_square_total[a]);
            v = axis_total[a] < 0 ? -axis_total[a] : axis_total[a];
            wide_mag = 128'(v);
            numerator = numerator + wide_n * wide_sq - wide_mag * wide_mag;
         end
         numerator = numerator << FRAC_BITS;
         divisor = 128'(3) * wide_n * (wide_n - 128'(1));
         quotient = numerator / divisor;
         result.variance = (quotient > 128'(VAR_MAX)) ? VAR_MAX : quotient[VAR_BITS-1:0];
         result.status = set_overflowed ? STATUS_OVERFLOW : STATUS_OK;
      end
      expected_variances.insert(expected_variances.size(), result);
      clear_set();
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_result();
      variance_result_type want;
      if (expected_variances.size() == 0) begin
         report_mismatch("unexpected result word, variance", 64'(rsp_mean_variance), '0);
         return;
      end
      want = expected_variances.pop_front();
      if (rsp_mean_variance !== want.variance) begin
         report_mismatch("mean_variance", 64'(rsp_mean_variance), 64'(want.variance));
      end
      if (rsp_status !== want.status) begin
         report_mismatch("status", 64'(rsp_status), 64'(want.status));
      end
      if (rsp_samples_used !== want.used) begin
         report_mismatch("samples_used", 64'(rsp_samples_used), 64'(want.used));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         check_result();
      end
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_ready = 1'b0;
            rsp_hold--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            stall_left = idle_length();
            rsp_ready = (stall_left == 0);
         end
      end
   end

   task automatic send_sample(input logic [SAMPLE_BITS-1:0] sx, input logic [SAMPLE_BITS-1:0] sy,
                              input logic [SAMPLE_BITS-1:0] sz, input logic last);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_sample_x = sx;
      req_sample_y = sy;
      req_sample_z = sz;
      req_last_sample = last;
      do @(posedge clock); while (!req_ready);
      absorb_sample(sx, sy, sz, last);
      words_sent++;
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample(int mode, int centre);
      int value;
      case (mode)
         2: begin
            value = centre + int'($urandom_range(0, 128)) - 64;
            if (value > 32767) value = 32767;
            if (value < -32768) value = -32768;
            return SAMPLE_BITS'(value);
         end
         3: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'h0000;
               default: return 16'hffff;
            endcase
         end
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic send_random_set(input int length, input int mode);
      int cx;
      int cy;
      int cz;
      cx = int'($urandom_range(0, 65535)) - 32768;
      cy = int'($urandom_range(0, 65535)) - 32768;
      cz = int'($urandom_range(0, 65535)) - 32768;
      for (int i = 0; i < length; i++) begin
         send_sample(pick_sample(mode, cx), pick_sample(mode, cy), pick_sample(mode, cz),
                     i == length - 1);
      end
   endtask

   task automatic test_single_sample_sets();
      send_sample(16'h7fff, 16'h8000, 16'h0000, 1'b1);
      send_sample(16'h8000, 16'h7fff, 16'hffff, 1'b1);
      send_sample(16'h0001, 16'h0000, 16'h8000, 1'b1);
   endtask

   task automatic test_two_sample_sets();
      send_sample(16'h8000, 16'h8000, 16'h8000, 1'b0);
      send_sample(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
      send_sample(16'h1234, 16'hfedc, 16'h0000, 1'b0);
      send_sample(16'h1234, 16'hfedc, 16'h0000, 1'b1);
      send_sample(16'h0001, 16'hffff, 16'h0000, 1'b0);
      send_sample(16'hffff, 16'h0001, 16'h0001, 1'b1);
   endtask

   task automatic test_extreme_sets();
      for (int i = 0; i < 6; i++) begin
         send_sample(i[0] ? 16'h7fff : 16'h8000, i[0] ? 16'h8000 : 16'h7fff,
                     i[1] ? 16'h7fff : 16'h8000, i == 5);
      end
      for (int i = 0; i < 5; i++) begin
         send_sample(16'h8000, 16'h8000, 16'h8000, i == 4);
      end
      for (int i = 0; i < 4; i++) begin
         send_sample(16'h5555 << i[0], 16'haaaa >> i[0], 16'h7fff - 16'(i), i == 3);
      end
   endtask

   task automatic test_full_set();
      send_random_set(MAX_SAMPLES, 0);
   endtask

   task automatic test_overflow_set();
      send_random_set(MAX_SAMPLES + 4, 0);
      send_random_set(3, 0);
   endtask

   task automatic test_backpressure();
      no_idle = 1'b1;
      rsp_hold = 400;
      for (int s = 0; s < 30; s++) begin
         send_random_set(2, $urandom_range(0, 3));
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_sets();
      int stop_at;
      int pick;
      int length;
      stop_at = words_sent + 1450;
      while (words_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            length = $urandom_range(1, 2);
         end else if (pick < 70) begin
            length = $urandom_range(3, 12);
         end else if (pick < 95) begin
            length = $urandom_range(13, 64);
         end else begin
            length = $urandom_range(65, 300);
         end
         no_idle = ($urandom_range(0, 3) == 0);
         send_random_set(length, $urandom_range(0, 3));
      end
      no_idle = 1'b0;
   endtask

   task automatic drain_results();
      int                  waited;
      variance_result_type lost;
      waited = 0;
      req_valid = 1'b0;
      while (expected_variances.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      while (expected_variances.size() != 0) begin
         lost = expected_variances.pop_front();
         report_mismatch("missing result word, samples_used", '0, 64'(lost.used));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_x = '0;
      req_sample_y = '0;
      req_sample_z = '0;
      req_last_sample = 1'b0;
      mismatch_count = 0;
      words_sent = 0;
      rsp_hold = 0;
      no_idle = 1'b0;
      clear_set();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_sample_sets();
      test_two_sample_sets();
      test_extreme_sets();
      test_full_set();
      test_overflow_set();
      test_backpressure();
      test_random_sets();
      drain_results();

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
